/* src/lccr_pkg.sv */
// Shared definitions for the letter count coin reachability block.
// Holds parameter defaults, item kind codes and the sequencer state type.
// No dependencies.
package lccr_pkg;

	// Default table limit and alphabet size.
	localparam int COUNT_LIMIT_DEF   = 4095;
	localparam int ALPHABET_SIZE_DEF = 26;

	// Item kind carried on tuser.
	localparam logic CMD_SOURCE = 1'b0;
	localparam logic CMD_TARGET = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_COIN_RD,
		ST_COIN_CHK,
		ST_SWEEP,
		ST_TGT_RD,
		ST_TGT_REACH,
		ST_TGT_BIT,
		ST_FINISH
	} state_t;

endpackage

/* src/lccr_reach_ram.sv */
// One-bit reachability table: one write port and two registered read ports.
// A read that meets a write to the same entry on the same edge gets the new bit.
// Takes its default size from lccr_pkg.
module lccr_reach_ram
	import lccr_pkg::*;
#(
	parameter int DEPTH = COUNT_LIMIT_DEF + 1,
	parameter int AW    = $clog2(COUNT_LIMIT_DEF + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic          rdata_a,
	output logic          rdata_b
);

	logic mem_q [DEPTH];
	logic rd_a_q;
	logic rd_b_q;
	logic hit_a_q;
	logic hit_b_q;
	logic wd_q;

	// Storage write and registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
		wd_q   <= wdata;
	end

	// Note when a read and a write hit the same entry on the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			hit_a_q <= we && (waddr == raddr_a);
			hit_b_q <= we && (waddr == raddr_b);
		end
	end

	// Forward the freshly written bit over the stale array read.
	assign rdata_a = hit_a_q ? wd_q : rd_a_q;
	assign rdata_b = hit_b_q ? wd_q : rd_b_q;

endmodule

/* src/letter_count_coin_reachability.sv */
// Letter counter with a coin-change reachability check, top level.
// Uses lccr_pkg and the table memory lccr_reach_ram.
//
// Input channel s_*: one letter per item. s_tdata[4:0] is the letter index,
// s_tuser says whether it belongs to the source or the target string, and
// s_tlast marks the final letter of both strings. Letters are counted at one
// item per cycle through a read-modify-write of the count memory, with
// forwarding when the same letter arrives on consecutive cycles.
// After the last item the block stops accepting and runs the check: a clearing
// pass over every table entry, then for each source letter a fetch of its count
// (COIN_RD, COIN_CHK) and, when the count is nonzero, a sweep from the count up
// to COUNT_LIMIT, then a read of each target letter's count and its table bit
// (TGT_RD, TGT_REACH, TGT_BIT), then the finish state. The sweep updates one
// table entry per cycle.
// Output channel m_*: one item per batch carrying no_case and overflow. The
// result waits in an output register while the receiver stalls, and new
// letters are accepted meanwhile; a later check holds in its finish cycle
// until that register is free.
// Reset clears all counts, the overflow flag and the output; the table itself
// is written in full by every check and needs no reset.
module letter_count_coin_reachability
	import lccr_pkg::*;
#(
	parameter int COUNT_LIMIT   = COUNT_LIMIT_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [4:0] letter, [7:5] zero
	input  logic       s_tuser,   // [0] cmd
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] no_case, [1] overflow, [7:2] zero
);

	localparam int CW     = $clog2(COUNT_LIMIT + 1);
	localparam int IW     = $clog2(ALPHABET_SIZE);
	localparam int CDEPTH = 2 ** (IW + 1);

	state_t state_q;
	state_t state_d;

	// Count memory, its valid bits and the registered read.
	logic [CW-1:0]   cnt_mem_q [CDEPTH];
	logic [CDEPTH-1:0] cnt_vld_q;
	logic [CW-1:0]   cnt_rd_q;
	logic            cnt_rd_vld_q;
	logic            cnt_hit_q;
	logic [CW-1:0]   cnt_wd_q;
	logic [IW:0]     cnt_raddr;
	logic            cnt_we;
	logic [CW-1:0]   cnt_wdata;
	logic [CW-1:0]   cnt_old;

	// Counting stage.
	logic            s1_cnt_s1;
	logic            s1_last_s1;
	logic [IW:0]     s1_addr_s1;
	logic            in_accept;
	logic            in_range;
	logic            overflow_q;

	// Sequencer counters.
	logic [IW-1:0]   a_q;
	logic [CW-1:0]   j_q;
	logic [CW-1:0]   coin_q;
	logic            missing_q;
	logic            a_last;
	logic            j_last;

	// Sweep write stage and table ports.
	logic            sw_valid_s1;
	logic [CW-1:0]   sw_addr_s1;
	logic            rt_we;
	logic [CW-1:0]   rt_waddr;
	logic            rt_wdata;
	logic [CW-1:0]   rt_raddr_a;
	logic [CW-1:0]   rt_raddr_b;
	logic            rt_rdata_a;
	logic            rt_rdata_b;

	// Output register.
	logic            out_valid_q;
	logic            out_nocase_q;
	logic            out_ovf_q;
	logic            out_load;

	assign in_accept = s_tvalid && s_tready;
	assign in_range  = (32'(s_tdata[4:0]) < ALPHABET_SIZE);
	assign a_last    = (a_q == IW'(ALPHABET_SIZE - 1));
	assign j_last    = (j_q == CW'(COUNT_LIMIT));
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	// Old count of the letter being read, with same-edge write forwarding.
	assign cnt_old = cnt_hit_q ? cnt_wd_q : (cnt_rd_vld_q ? cnt_rd_q : '0);

	// Saturating increment of the counting stage.
	assign cnt_we    = s1_cnt_s1;
	assign cnt_wdata = (cnt_old == CW'(COUNT_LIMIT)) ? cnt_old : cnt_old + CW'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (s1_last_s1) state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				if (j_last) state_d = ST_COIN_RD;
			end
			ST_COIN_RD: begin
				state_d = ST_COIN_CHK;
			end
			ST_COIN_CHK: begin
				if (cnt_old != '0) state_d = ST_SWEEP;
				else if (a_last) state_d = ST_TGT_RD;
				else state_d = ST_COIN_RD;
			end
			ST_SWEEP: begin
				if (j_last) state_d = a_last ? ST_TGT_RD : ST_COIN_RD;
			end
			ST_TGT_RD: begin
				state_d = ST_TGT_REACH;
			end
			ST_TGT_REACH: begin
				state_d = ST_TGT_BIT;
			end
			ST_TGT_BIT: begin
				state_d = a_last ? ST_FINISH : ST_TGT_RD;
			end
			ST_FINISH: begin
				if (out_load) state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// Memory addresses and write strobes for each state.
	always_comb begin
		s_tready   = 1'b0;
		cnt_raddr  = {s_tuser, IW'(s_tdata[4:0])};
		rt_raddr_a = j_q;
		rt_raddr_b = j_q - coin_q;
		rt_we      = sw_valid_s1;
		rt_waddr   = sw_addr_s1;
		rt_wdata   = rt_rdata_a | rt_rdata_b;
		case (state_q)
			ST_LOAD: begin
				s_tready = !s1_last_s1;
			end
			ST_CLEAR: begin
				rt_we    = 1'b1;
				rt_waddr = j_q;
				rt_wdata = (j_q == '0);
			end
			ST_COIN_RD: begin
				cnt_raddr = {CMD_SOURCE, a_q};
			end
			ST_TGT_RD: begin
				cnt_raddr = {CMD_TARGET, a_q};
			end
			ST_TGT_REACH: begin
				rt_raddr_a = cnt_old;
			end
			default: begin
			end
		endcase
	end

	// Count memory storage and registered read.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem_q[s1_addr_s1] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem_q[cnt_raddr];
		cnt_wd_q <= cnt_wdata;
	end

	// Control registers, counters and the output item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			cnt_vld_q    <= '0;
			cnt_rd_vld_q <= 1'b0;
			cnt_hit_q    <= 1'b0;
			s1_cnt_s1    <= 1'b0;
			s1_last_s1   <= 1'b0;
			s1_addr_s1   <= '0;
			overflow_q   <= 1'b0;
			a_q          <= '0;
			j_q          <= '0;
			coin_q       <= '0;
			missing_q    <= 1'b0;
			sw_valid_s1  <= 1'b0;
			sw_addr_s1   <= '0;
			out_valid_q  <= 1'b0;
			out_nocase_q <= 1'b0;
			out_ovf_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_rd_vld_q <= cnt_vld_q[cnt_raddr];
			cnt_hit_q    <= cnt_we && (s1_addr_s1 == cnt_raddr);

			// Counting stage: capture the item, then update its count.
			s1_cnt_s1  <= in_accept && in_range;
			s1_last_s1 <= in_accept && s_tlast;
			s1_addr_s1 <= cnt_raddr;
			if (cnt_we) begin
				cnt_vld_q[s1_addr_s1] <= 1'b1;
				if (cnt_old == CW'(COUNT_LIMIT)) overflow_q <= 1'b1;
			end

			// Sweep write follows each sweep read in the next cycle.
			sw_valid_s1 <= (state_q == ST_SWEEP);
			sw_addr_s1  <= j_q;

			case (state_q)
				ST_LOAD: begin
					j_q       <= '0;
					a_q       <= '0;
					missing_q <= 1'b0;
				end
				ST_CLEAR: begin
					j_q <= j_q + CW'(1);
				end
				ST_COIN_CHK: begin
					if (cnt_old != '0) begin
						j_q    <= cnt_old;
						coin_q <= cnt_old;
					end else begin
						a_q <= a_last ? '0 : a_q + IW'(1);
					end
				end
				ST_SWEEP: begin
					j_q <= j_q + CW'(1);
					if (j_last) a_q <= a_last ? '0 : a_q + IW'(1);
				end
				ST_TGT_BIT: begin
					if (!rt_rdata_a) missing_q <= 1'b1;
					a_q <= a_q + IW'(1);
				end
				default: begin
				end
			endcase

			// Hand the result over and start a new batch.
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_nocase_q <= missing_q;
				out_ovf_q    <= overflow_q;
				cnt_vld_q    <= '0;
				overflow_q   <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	lccr_reach_ram #(
		.DEPTH(COUNT_LIMIT + 1),
		.AW   (CW)
	) u_reach_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (rt_we),
		.waddr  (rt_waddr),
		.wdata  (rt_wdata),
		.raddr_a(rt_raddr_a),
		.raddr_b(rt_raddr_b),
		.rdata_a(rt_rdata_a),
		.rdata_b(rt_rdata_b)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_ovf_q, out_nocase_q};

endmodule
